// File: design/dqqp_pkg.sv
// Shared types and constants for the DNS question parser.
package dqqp_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned TAIL_BYTES   = 4;
  localparam logic [7:0]  LABEL_KIND_MASK = 8'hC0;
  localparam logic [7:0]  DOT_CHAR = 8'h2E;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_LABEL,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  name_char;
    status_t     status;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_length;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      first;
    item_t      second;
  } push_t;

endpackage

// File: design/dqqp_front.sv
// Byte parser: walks header, labels and type/class and emits up to two items per byte.
module dqqp_front #(
  parameter int unsigned NAME_CAP = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  output dqqp_pkg::push_t   push
);

  localparam logic [9:0] CAP = 10'(NAME_CAP);

  dqqp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [5:0]  label_rem_r, label_rem_nxt;
  logic [7:0]  chars_r, chars_nxt;
  logic        dot_r, dot_nxt;
  logic [1:0]  tail_idx_r, tail_idx_nxt;
  logic [23:0] tc_r, tc_nxt;

  function automatic dqqp_pkg::item_t mk_char(input logic [7:0] ch);
    dqqp_pkg::item_t it;
    it = '0;
    it.name_char = ch;
    it.status = dqqp_pkg::ST_OK;
    return it;
  endfunction

  function automatic dqqp_pkg::item_t mk_verdict(input dqqp_pkg::status_t st,
                                                 input logic [15:0] ty,
                                                 input logic [15:0] cl,
                                                 input logic [7:0] nl);
    dqqp_pkg::item_t it;
    it = '0;
    it.is_verdict = 1'b1;
    it.status = st;
    it.query_type = ty;
    it.query_class = cl;
    it.name_length = nl;
    return it;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dqqp_pkg::PH_HEADER;
      hdr_idx_r   <= '0;
      count_r     <= '0;
      label_rem_r <= '0;
      chars_r     <= '0;
      dot_r       <= 1'b0;
      tail_idx_r  <= '0;
      tc_r        <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      count_r     <= count_nxt;
      label_rem_r <= label_rem_nxt;
      chars_r     <= chars_nxt;
      dot_r       <= dot_nxt;
      tail_idx_r  <= tail_idx_nxt;
      tc_r        <= tc_nxt;
    end
  end

  always_comb begin
    logic            done;
    logic [1:0]      n;
    dqqp_pkg::item_t it0;
    dqqp_pkg::item_t it1;
    logic [9:0]      need;

    phase_nxt     = phase_r;
    hdr_idx_nxt   = hdr_idx_r;
    count_nxt     = count_r;
    label_rem_nxt = label_rem_r;
    chars_nxt     = chars_r;
    dot_nxt       = dot_r;
    tail_idx_nxt  = tail_idx_r;
    tc_nxt        = tc_r;
    done = 1'b0;
    n    = 2'd0;
    it0  = '0;
    it1  = '0;
    need = {2'b00, chars_r} + {2'b00, data_byte} + 10'd1;

    case (phase_r)
      dqqp_pkg::PH_HEADER: begin
        if (hdr_idx_r == 4'd4) begin
          count_nxt = data_byte;
        end else if (hdr_idx_r == 4'd5) begin
          count_nxt = count_r | data_byte;
        end
        if (hdr_idx_r >= 4'(dqqp_pkg::HEADER_BYTES - 1)) begin
          if (count_r == 8'd0) begin
            it0 = mk_verdict(dqqp_pkg::ST_NONE, 16'd0, 16'd0, 8'd0);
            n = 2'd1;
            done = 1'b1;
            phase_nxt = dqqp_pkg::PH_SKIP;
          end else begin
            phase_nxt = dqqp_pkg::PH_LEN;
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
        end
      end
      dqqp_pkg::PH_LEN: begin
        if (dot_r) begin
          it0 = mk_char(dqqp_pkg::DOT_CHAR);
          n = 2'd1;
          dot_nxt = 1'b0;
        end
        if (data_byte == 8'd0) begin
          if (chars_r == 8'd0) begin
            done = 1'b1;
          end else begin
            phase_nxt = dqqp_pkg::PH_TAIL;
            tail_idx_nxt = '0;
            tc_nxt = '0;
          end
        end else if ((data_byte & dqqp_pkg::LABEL_KIND_MASK) != 8'd0 || need >= CAP) begin
          done = 1'b1;
        end else begin
          label_rem_nxt = data_byte[5:0];
          phase_nxt = dqqp_pkg::PH_LABEL;
        end
        if (done) begin
          if (n == 2'd0) begin
            it0 = mk_verdict(dqqp_pkg::ST_MALFORMED, 16'd0, 16'd0, 8'd0);
          end else begin
            it1 = mk_verdict(dqqp_pkg::ST_MALFORMED, 16'd0, 16'd0, 8'd0);
          end
          n = n + 2'd1;
          phase_nxt = dqqp_pkg::PH_SKIP;
        end
      end
      dqqp_pkg::PH_LABEL: begin
        it0 = mk_char(data_byte);
        n = 2'd1;
        label_rem_nxt = label_rem_r - 6'd1;
        if (label_rem_r == 6'd1) begin
          dot_nxt = 1'b1;
          chars_nxt = chars_r + 8'd2;
          phase_nxt = dqqp_pkg::PH_LEN;
        end else begin
          chars_nxt = chars_r + 8'd1;
        end
      end
      dqqp_pkg::PH_TAIL: begin
        if (tail_idx_r >= 2'(dqqp_pkg::TAIL_BYTES - 1)) begin
          it0 = mk_verdict(dqqp_pkg::ST_OK, tc_r[23:8], {tc_r[7:0], data_byte}, chars_r);
          n = 2'd1;
          done = 1'b1;
          phase_nxt = dqqp_pkg::PH_SKIP;
        end else begin
          tc_nxt = {tc_r[15:0], data_byte};
          tail_idx_nxt = tail_idx_r + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (end_of_packet) begin
      if (!done && phase_nxt != dqqp_pkg::PH_SKIP) begin
        if (n == 2'd0) begin
          it0 = mk_verdict(dqqp_pkg::ST_MALFORMED, 16'd0, 16'd0, 8'd0);
        end else begin
          it1 = mk_verdict(dqqp_pkg::ST_MALFORMED, 16'd0, 16'd0, 8'd0);
        end
        n = n + 2'd1;
      end
      phase_nxt     = dqqp_pkg::PH_HEADER;
      hdr_idx_nxt   = '0;
      count_nxt     = '0;
      label_rem_nxt = '0;
      chars_nxt     = '0;
      dot_nxt       = 1'b0;
      tail_idx_nxt  = '0;
      tc_nxt        = '0;
    end

    push.cnt    = accept ? n : 2'd0;
    push.first  = it0;
    push.second = it1;
  end

endmodule

// File: design/dqqp_queue.sv
// Small item queue between parser and output stage; takes up to two items per cycle.
module dqqp_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dqqp_pkg::push_t                  push,
  input  logic                             pop,
  output dqqp_pkg::item_t                  head,
  output logic [dqqp_pkg::QCNT_W-1:0]      count,
  output logic                             space_ok
);

  dqqp_pkg::item_t mem_r [dqqp_pkg::QDEPTH];
  logic [dqqp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dqqp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dqqp_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [dqqp_pkg::QPTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + dqqp_pkg::QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + dqqp_pkg::QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + dqqp_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + dqqp_pkg::QCNT_W'(push.cnt) - dqqp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head     = mem_r[rd_ptr_r];
  assign count    = count_r;
  assign space_ok = count_r <= dqqp_pkg::QCNT_W'(dqqp_pkg::QDEPTH - 2);

endmodule

// File: design/dqqp_back.sv
// Output register stage: loads the queue head and holds it until taken.
module dqqp_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_nonempty,
  input  dqqp_pkg::item_t                       head,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dqqp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);

  logic            valid_r;
  dqqp_pkg::item_t item_r;

  assign pop = q_nonempty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = item_r.is_verdict;
  assign out_tdata  = {6'b0, item_r.name_length, item_r.query_class, item_r.query_type,
                       item_r.status, item_r.name_char};

endmodule

// File: design/dns_query_question_parser.sv
// Top level of the DNS first-question parser.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] data_byte, tlast end_of_packet
//  out_    | out | out_tvalid/out_tready| tdata name_char..name_length, tlast is_verdict
//
// One input byte per cycle while in_tready is high; each byte yields zero, one or two items.
// Items pass through a four-entry queue into a registered output stage.
// The input stalls only while the queue holds more than two items.
// Reset (rst_n low, synchronous) returns the parser to the header phase.
module dns_query_question_parser #(
  parameter int unsigned NAME_CAP = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] data_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] name_char, [9:8] status, [25:10] query_type, [41:26] query_class,
  // [49:42] name_length, [55:50] zero
  output logic [dqqp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  dqqp_pkg::push_t             push;
  dqqp_pkg::item_t             head;
  logic [dqqp_pkg::QCNT_W-1:0] q_count;
  logic                        space_ok;
  logic                        pop;
  logic                        accept;

  assign in_tready = space_ok;
  assign accept    = in_tvalid && in_tready;

  dqqp_front #(.NAME_CAP(NAME_CAP)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .push          (push)
  );

  dqqp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .count    (q_count),
    .space_ok (space_ok)
  );

  dqqp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_count != '0),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= dqqp_pkg::QCNT_W'(dqqp_pkg::QDEPTH))
    else $error("queue overfilled");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> accept)
    else $error("items pushed without an accepted byte");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> (!push.first.is_verdict && push.second.is_verdict))
    else $error("two-item byte must end in a verdict");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count != '0 && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("output stage failed to load a waiting item");

endmodule
